@@ src/assert_macros.svh @@
// assertion macros used by the name table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AST_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMP(lbl, clk, rst, ante, cons, msg)
`define AST_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/ntss_pkg.sv @@
// shared codes, datapath operations and control/status types
package ntss_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_SEARCH = 3'd2;
  localparam logic [2:0] KIND_SORT   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [5:0] {
    OP_NONE, OP_INIT, OP_ACCEPT, OP_ADD_WR, OP_WOFS_CLR,
    OP_RM_RD, OP_RM_CAP, OP_RM_RD2, OP_RM_W, OP_RM_FIN,
    OP_PAT_WR, OP_PLEN_CLR, OP_SR_MAP, OP_SR_LEN, OP_SR_S0, OP_SR_RD,
    OP_K_INC, OP_S_INC, OP_NEXT_I, OP_PEND_SET,
    OP_SORT_INIT, OP_J_INIT, OP_SO_RA, OP_SO_RB, OP_SO_LA, OP_SO_LB,
    OP_SO_K0, OP_SO_BA, OP_SO_BB, OP_SO_SW1, OP_SO_SW2, OP_J_INC,
    OP_RD_MAP, OP_RD_LEN, OP_RD_BYTE, OP_RD_CAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] st;
    logic       hit;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       last;
    logic       full;
    logic       empty;
    logic       rm_bad;
    logic       rd_bad;
    logic       i_eq_cnt;
    logic       i_last;
    logic       j_last;
    logic       init_done;
    logic       fits;
    logic       eq_pat;
    logic       k_last;
    logic       k_at_min;
    logic       len_gt;
    logic       b_gt;
    logic       b_eq;
    logic       pend;
    logic       out_free;
  } stat_t;

endpackage

@@ src/ntss_ram.sv @@
// generic single write port ram with registered read
module ntss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/ntss_dp.sv @@
// name table datapath: slot map, lengths, name bytes, pattern and result register
`include "assert_macros.svh"
module ntss_dp import ntss_pkg::*; #(
  parameter int ENTRIES  = 32,
  parameter int NAME_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] kind,
  input  logic [7:0] char_byte,
  input  logic       last,
  input  logic [5:0] position,
  input  logic [4:0] offset,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] status,
  output logic       matched,
  output logic [4:0] match_index,
  output logic [7:0] byte_out,
  output logic [5:0] count,
  output logic       last_result
);

  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = $clog2(NAME_LEN);
  localparam int AW = $clog2(ENTRIES * NAME_LEN);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int OW = (LW > 5) ? LW : 5;

  logic [CW-1:0] entry_count;
  logic [LW-1:0] wofs, plen, k, s, len_a, len_b;
  logic [CW-1:0] i, j;
  logic [EW-1:0] slot_a, slot_b, pidx;
  logic [7:0]    byte_a, res_byte;
  logic          pend;
  logic [2:0]    in_kind;
  logic [7:0]    in_ch;
  logic          in_last;
  logic [5:0]    in_pos;
  logic [4:0]    in_off;

  logic          map_we, len_we, name_we, pat_we;
  logic [EW-1:0] map_waddr, map_wdata, map_raddr, map_rdata;
  logic [EW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_wdata, len_rdata;
  logic [AW-1:0] name_waddr, name_raddr;
  logic [7:0]    name_rdata, pat_rdata;
  logic [LW-1:0] pat_raddr;

  logic          wofs_room, pat_room, out_free, off_ok;
  logic [LW-1:0] wofs_n, len_min;

  function automatic logic [AW-1:0] name_addr(input logic [EW-1:0] slot,
                                              input logic [AW-1:0] ofs);
    return AW'(slot) * AW'(NAME_LEN) + ofs;
  endfunction

  assign wofs_room = wofs < LW'(NAME_LEN - 1);
  assign wofs_n    = wofs_room ? wofs + LW'(1) : wofs;
  assign pat_room  = plen < LW'(NAME_LEN - 1);
  assign out_free  = !out_valid || out_ready;
  assign len_min   = (len_a < len_b) ? len_a : len_b;
  assign off_ok    = OW'(in_off) < OW'(len_a);

  always_comb begin
    stat.kind      = in_kind;
    stat.last      = in_last;
    stat.full      = entry_count == CW'(ENTRIES);
    stat.empty     = entry_count == '0;
    stat.rm_bad    = (in_pos == 6'd0) || (PW'(in_pos) > PW'(entry_count));
    stat.rd_bad    = PW'(in_pos) >= PW'(entry_count);
    stat.i_eq_cnt  = i == entry_count;
    stat.i_last    = (CW + 1)'(i) + (CW + 1)'(1) >= (CW + 1)'(entry_count);
    stat.j_last    = (CW + 1)'(j) + (CW + 1)'(1) == (CW + 1)'(entry_count);
    stat.init_done = i == CW'(ENTRIES - 1);
    stat.fits      = (LW + 1)'(s) + (LW + 1)'(plen) <= (LW + 1)'(len_a);
    stat.eq_pat    = name_rdata == pat_rdata;
    stat.k_last    = (LW + 1)'(k) + (LW + 1)'(1) == (LW + 1)'(plen);
    stat.k_at_min  = k == len_min;
    stat.len_gt    = len_a > len_b;
    stat.b_gt      = byte_a > name_rdata;
    stat.b_eq      = byte_a == name_rdata;
    stat.pend      = pend;
    stat.out_free  = out_free;
  end

  always_comb begin
    map_we     = 1'b0;
    map_waddr  = EW'(i);
    map_wdata  = slot_a;
    map_raddr  = EW'(i);
    len_we     = 1'b0;
    len_waddr  = map_rdata;
    len_wdata  = wofs_n;
    len_raddr  = map_rdata;
    name_we    = 1'b0;
    name_waddr = name_addr(map_rdata, AW'(wofs));
    name_raddr = name_addr(slot_a, AW'(k));
    pat_we     = 1'b0;
    pat_raddr  = k;
    case (cmd.op)
      OP_INIT: begin
        map_we    = 1'b1;
        map_wdata = EW'(i);
      end
      OP_ACCEPT: map_raddr = EW'(entry_count);
      OP_ADD_WR: begin
        name_we = wofs_room;
        len_we  = in_last;
      end
      OP_RM_RD: map_raddr = EW'(in_pos - 6'd1);
      OP_RM_W: begin
        map_we    = 1'b1;
        map_waddr = EW'(i - CW'(1));
        map_wdata = map_rdata;
      end
      OP_RM_FIN: begin
        map_we    = 1'b1;
        map_waddr = EW'(entry_count - CW'(1));
      end
      OP_PAT_WR: pat_we = pat_room;
      OP_SR_RD: name_raddr = name_addr(slot_a, AW'(s) + AW'(k));
      OP_SO_RB: map_raddr = EW'(j);
      OP_SO_LA: len_raddr = slot_a;
      OP_SO_LB: len_raddr = slot_b;
      OP_SO_BB: name_raddr = name_addr(slot_b, AW'(k));
      OP_SO_SW1: begin
        map_we    = 1'b1;
        map_wdata = slot_b;
      end
      OP_SO_SW2: begin
        map_we    = 1'b1;
        map_waddr = EW'(j);
      end
      OP_RD_MAP: map_raddr = EW'(in_pos);
      OP_RD_BYTE: name_raddr = name_addr(slot_a, AW'(in_off));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      wofs        <= '0;
      plen        <= '0;
      i           <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        status      <= cmd.st;
        matched     <= cmd.hit;
        match_index <= cmd.hit ? 5'(pidx) : 5'd0;
        byte_out    <= res_byte;
        count       <= 6'(entry_count);
        last_result <= cmd.fin;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_INIT: i <= i + CW'(1);
        OP_ACCEPT: begin
          in_kind  <= kind;
          in_ch    <= char_byte;
          in_last  <= last;
          in_pos   <= position;
          in_off   <= offset;
          res_byte <= 8'd0;
          pend     <= 1'b0;
          if (kind <= KIND_READ) begin
            if (kind != KIND_ADD) wofs <= '0;
            if (kind != KIND_SEARCH) plen <= '0;
          end
        end
        OP_ADD_WR: begin
          if (in_last) begin
            wofs        <= '0;
            entry_count <= entry_count + CW'(1);
          end else begin
            wofs <= wofs_n;
          end
        end
        OP_WOFS_CLR: wofs <= '0;
        OP_RM_RD: i <= CW'(in_pos);
        OP_RM_CAP: slot_a <= map_rdata;
        OP_RM_W: i <= i + CW'(1);
        OP_RM_FIN: entry_count <= entry_count - CW'(1);
        OP_PAT_WR: begin
          if (pat_room) plen <= plen + LW'(1);
          i <= '0;
        end
        OP_PLEN_CLR: plen <= '0;
        OP_SR_LEN: slot_a <= map_rdata;
        OP_SR_S0: begin
          len_a <= len_rdata;
          s     <= '0;
          k     <= '0;
        end
        OP_K_INC: k <= k + LW'(1);
        OP_S_INC: begin
          s <= s + LW'(1);
          k <= '0;
        end
        OP_NEXT_I: i <= i + CW'(1);
        OP_PEND_SET: begin
          pend <= 1'b1;
          pidx <= EW'(i);
          i    <= i + CW'(1);
        end
        OP_SORT_INIT: i <= '0;
        OP_J_INIT: j <= i + CW'(1);
        OP_SO_RB: slot_a <= map_rdata;
        OP_SO_LA: slot_b <= map_rdata;
        OP_SO_LB: len_a <= len_rdata;
        OP_SO_K0: begin
          len_b <= len_rdata;
          k     <= '0;
        end
        OP_SO_BB: byte_a <= name_rdata;
        OP_J_INC: j <= j + CW'(1);
        OP_RD_LEN: slot_a <= map_rdata;
        OP_RD_BYTE: len_a <= len_rdata;
        OP_RD_CAP: res_byte <= off_ok ? name_rdata : 8'd0;
        default: ;
      endcase
    end
  end

  ntss_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  ntss_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  ntss_ram #(.WIDTH(8), .DEPTH(ENTRIES * NAME_LEN)) u_name (
    .clk(clk), .we(name_we), .waddr(name_waddr), .wdata(in_ch),
    .raddr(name_raddr), .rdata(name_rdata)
  );

  ntss_ram #(.WIDTH(8), .DEPTH(NAME_LEN)) u_pat (
    .clk(clk), .we(pat_we), .waddr(plen), .wdata(in_ch),
    .raddr(pat_raddr), .rdata(pat_rdata)
  );

  `AST_IMP(a_cnt_max, clk, rst, 1'b1, entry_count <= CW'(ENTRIES), "entry count above capacity")
  `AST_IMP(a_emit_free, clk, rst, cmd.emit, out_free, "result word written while output busy")
  `AST_NXT(a_rm_dec, clk, rst, cmd.op == OP_RM_FIN, entry_count == $past(entry_count) - CW'(1), "remove did not shrink table")

endmodule

@@ src/ntss_ctrl.sv @@
// name table controller: sequences add, remove, search, sort and read
module ntss_ctrl import ntss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [29:0] {
    S_INIT     = 30'd1 << 0,
    S_IDLE     = 30'd1 << 1,
    S_DISP     = 30'd1 << 2,
    S_EMIT     = 30'd1 << 3,
    S_RM_CAP   = 30'd1 << 4,
    S_RM_LOOP  = 30'd1 << 5,
    S_RM_W     = 30'd1 << 6,
    S_SR_EMPTY = 30'd1 << 7,
    S_SR_E     = 30'd1 << 8,
    S_SR_L     = 30'd1 << 9,
    S_SR_S0    = 30'd1 << 10,
    S_SR_RD    = 30'd1 << 11,
    S_SR_CK    = 30'd1 << 12,
    S_SR_HIT   = 30'd1 << 13,
    S_SR_FIN   = 30'd1 << 14,
    S_SO_I     = 30'd1 << 15,
    S_SO_RA    = 30'd1 << 16,
    S_SO_RB    = 30'd1 << 17,
    S_SO_LA    = 30'd1 << 18,
    S_SO_LB    = 30'd1 << 19,
    S_SO_K0    = 30'd1 << 20,
    S_SO_BA    = 30'd1 << 21,
    S_SO_BB    = 30'd1 << 22,
    S_SO_BC    = 30'd1 << 23,
    S_SO_SW1   = 30'd1 << 24,
    S_SO_SW2   = 30'd1 << 25,
    S_SO_NJ    = 30'd1 << 26,
    S_RD_L     = 30'd1 << 27,
    S_RD_B     = 30'd1 << 28,
    S_RD_V     = 30'd1 << 29
  } state_t;

  state_t     state, state_next;
  logic [1:0] st_code, st_code_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      st_code <= ST_OK;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

  always_comb begin
    state_next   = state;
    st_code_next = st_code;
    cmd          = '{op: OP_NONE, emit: 1'b0, st: ST_OK, hit: 1'b0, fin: 1'b0};
    unique case (state)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (stat.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        st_code_next = ST_OK;
        state_next   = S_EMIT;
        case (stat.kind)
          KIND_ADD: begin
            if (stat.full) begin
              cmd.op       = OP_WOFS_CLR;
              st_code_next = ST_FULL;
            end else begin
              cmd.op = OP_ADD_WR;
            end
          end
          KIND_REMOVE: begin
            if (stat.empty) st_code_next = ST_EMPTY;
            else if (stat.rm_bad) st_code_next = ST_BADPOS;
            else begin
              cmd.op     = OP_RM_RD;
              state_next = S_RM_CAP;
            end
          end
          KIND_SEARCH: begin
            cmd.op = OP_PAT_WR;
            if (stat.last) begin
              if (stat.empty) begin
                st_code_next = ST_EMPTY;
                state_next   = S_SR_EMPTY;
              end else begin
                state_next = S_SR_E;
              end
            end
          end
          KIND_SORT: begin
            if (stat.empty) st_code_next = ST_EMPTY;
            else begin
              cmd.op     = OP_SORT_INIT;
              state_next = S_SO_I;
            end
          end
          KIND_READ: begin
            if (stat.empty) st_code_next = ST_EMPTY;
            else if (stat.rd_bad) st_code_next = ST_BADPOS;
            else begin
              cmd.op     = OP_RD_MAP;
              state_next = S_RD_L;
            end
          end
          default: ;
        endcase
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.st     = st_code;
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RM_CAP: begin
        cmd.op     = OP_RM_CAP;
        state_next = S_RM_LOOP;
      end
      S_RM_LOOP: begin
        if (stat.i_eq_cnt) begin
          cmd.op     = OP_RM_FIN;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_RM_RD2;
          state_next = S_RM_W;
        end
      end
      S_RM_W: begin
        cmd.op     = OP_RM_W;
        state_next = S_RM_LOOP;
      end
      S_SR_EMPTY: begin
        cmd.op     = OP_PLEN_CLR;
        state_next = S_EMIT;
      end
      S_SR_E: begin
        if (stat.i_eq_cnt) state_next = S_SR_FIN;
        else begin
          cmd.op     = OP_SR_MAP;
          state_next = S_SR_L;
        end
      end
      S_SR_L: begin
        cmd.op     = OP_SR_LEN;
        state_next = S_SR_S0;
      end
      S_SR_S0: begin
        cmd.op     = OP_SR_S0;
        state_next = S_SR_RD;
      end
      S_SR_RD: begin
        if (stat.fits) begin
          cmd.op     = OP_SR_RD;
          state_next = S_SR_CK;
        end else begin
          cmd.op     = OP_NEXT_I;
          state_next = S_SR_E;
        end
      end
      S_SR_CK: begin
        if (!stat.eq_pat) begin
          cmd.op     = OP_S_INC;
          state_next = S_SR_RD;
        end else if (stat.k_last) begin
          state_next = S_SR_HIT;
        end else begin
          cmd.op     = OP_K_INC;
          state_next = S_SR_RD;
        end
      end
      S_SR_HIT: begin
        if (!stat.pend) begin
          cmd.op     = OP_PEND_SET;
          state_next = S_SR_E;
        end else if (stat.out_free) begin
          cmd.op     = OP_PEND_SET;
          cmd.emit   = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_SR_E;
        end
      end
      S_SR_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_PLEN_CLR;
          cmd.emit   = 1'b1;
          cmd.hit    = stat.pend;
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SO_I: begin
        if (stat.i_last) begin
          st_code_next = ST_OK;
          state_next   = S_EMIT;
        end else begin
          cmd.op     = OP_J_INIT;
          state_next = S_SO_RA;
        end
      end
      S_SO_RA: begin
        cmd.op     = OP_SO_RA;
        state_next = S_SO_RB;
      end
      S_SO_RB: begin
        cmd.op     = OP_SO_RB;
        state_next = S_SO_LA;
      end
      S_SO_LA: begin
        cmd.op     = OP_SO_LA;
        state_next = S_SO_LB;
      end
      S_SO_LB: begin
        cmd.op     = OP_SO_LB;
        state_next = S_SO_K0;
      end
      S_SO_K0: begin
        cmd.op     = OP_SO_K0;
        state_next = S_SO_BA;
      end
      S_SO_BA: begin
        if (stat.k_at_min) state_next = stat.len_gt ? S_SO_SW1 : S_SO_NJ;
        else begin
          cmd.op     = OP_SO_BA;
          state_next = S_SO_BB;
        end
      end
      S_SO_BB: begin
        cmd.op     = OP_SO_BB;
        state_next = S_SO_BC;
      end
      S_SO_BC: begin
        if (stat.b_eq) begin
          cmd.op     = OP_K_INC;
          state_next = S_SO_BA;
        end else begin
          state_next = stat.b_gt ? S_SO_SW1 : S_SO_NJ;
        end
      end
      S_SO_SW1: begin
        cmd.op     = OP_SO_SW1;
        state_next = S_SO_SW2;
      end
      S_SO_SW2: begin
        cmd.op     = OP_SO_SW2;
        state_next = S_SO_NJ;
      end
      S_SO_NJ: begin
        if (stat.j_last) begin
          cmd.op     = OP_NEXT_I;
          state_next = S_SO_I;
        end else begin
          cmd.op     = OP_J_INC;
          state_next = S_SO_RA;
        end
      end
      S_RD_L: begin
        cmd.op     = OP_RD_LEN;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.op     = OP_RD_BYTE;
        state_next = S_RD_V;
      end
      S_RD_V: begin
        cmd.op     = OP_RD_CAP;
        state_next = S_EMIT;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

@@ src/name_table_sort_search.sv @@
// add, pattern byte and unknown words pass through dispatch and emit; read also looks up slot, length and byte
// remove shifts each later slot map entry down; search walks every entry, one name ram port
// sort is an exchange sort over the slot map: each pair compares bytes in turn, swapping map entries if out of order
// one word in flight at a time; a waiting result word does not block the next accept
// after reset every slot map entry is written with its own index while in_ready is low
module name_table_sort_search import ntss_pkg::*; #(
  parameter int ENTRIES  = 32,
  parameter int NAME_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] kind,
  input  logic [7:0] char_byte,
  input  logic       last,
  input  logic [5:0] position,
  input  logic [4:0] offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic       matched,
  output logic [4:0] match_index,
  output logic [7:0] byte_out,
  output logic [5:0] count,
  output logic       last_result
);

  cmd_t  cmd;
  stat_t stat;

  ntss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  ntss_dp #(.ENTRIES(ENTRIES), .NAME_LEN(NAME_LEN)) u_dp (
    .clk(clk), .rst(rst), .kind(kind), .char_byte(char_byte), .last(last),
    .position(position), .offset(offset), .cmd(cmd), .stat(stat),
    .out_ready(out_ready), .out_valid(out_valid), .status(status),
    .matched(matched), .match_index(match_index), .byte_out(byte_out),
    .count(count), .last_result(last_result)
  );

endmodule

@@ sim/name_table_sort_search_tb.sv @@
// self-checking testbench for the name table with sort and substring search
module name_table_sort_search_tb import ntss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES  = 32;
  localparam int NAME_LEN = 32;
  localparam int STALL_LIMIT = 300000;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       fin;
    logic [5:0] pos;
    logic [4:0] off;
    bit         hold;
  } word_t;

  typedef struct {
    logic [1:0] status;
    logic       matched;
    logic [4:0] idx;
    logic [7:0] byte_v;
    logic [5:0] cnt;
    logic       fin;
  } reply_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] kind;
  logic [7:0] char_byte;
  logic       last;
  logic [5:0] position;
  logic [4:0] offset;
  logic [1:0] status;
  logic       matched;
  logic [4:0] match_index;
  logic [7:0] byte_out;
  logic [5:0] count;
  logic       last_result;

  name_table_sort_search dut (.*);

  word_t  pending[$];
  reply_t replies[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 0;

  logic [7:0] tbl_byte[ENTRIES][NAME_LEN];
  int         tbl_len[ENTRIES];
  int         tbl_cnt, pat_len, wr_ofs;
  logic [7:0] pat[NAME_LEN];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic void push_reply(logic [1:0] st, logic m, int ix, logic [7:0] b, logic f);
    reply_t r;
    r.status = st; r.matched = m; r.idx = ix[4:0]; r.byte_v = b;
    r.cnt = tbl_cnt[5:0]; r.fin = f;
    replies.push_back(r);
  endfunction

  function automatic bit contains(int e);
    bit ok;
    if (pat_len > tbl_len[e]) return 0;
    for (int s = 0; s + pat_len <= tbl_len[e]; s++) begin
      ok = 1;
      for (int k = 0; k < pat_len; k++) if (tbl_byte[e][s+k] != pat[k]) ok = 0;
      if (ok) return 1;
    end
    return 0;
  endfunction

  function automatic int name_order(int a, int b);
    int m;
    m = tbl_len[a] < tbl_len[b] ? tbl_len[a] : tbl_len[b];
    for (int k = 0; k < m; k++)
      if (tbl_byte[a][k] != tbl_byte[b][k]) return tbl_byte[a][k] > tbl_byte[b][k] ? 1 : -1;
    return tbl_len[a] > tbl_len[b] ? 1 : (tbl_len[a] < tbl_len[b] ? -1 : 0);
  endfunction

  function automatic void predict_table(word_t w);
    int hits, tl;
    logic [7:0] tb[NAME_LEN];
    if (w.kind > KIND_READ) begin
      push_reply(ST_OK, 0, 0, 0, 1);
      return;
    end
    if (w.kind != KIND_ADD) wr_ofs = 0;
    if (w.kind != KIND_SEARCH) pat_len = 0;
    case (w.kind)
      KIND_ADD: begin
        if (tbl_cnt >= ENTRIES) begin
          wr_ofs = 0;
          push_reply(ST_FULL, 0, 0, 0, 1);
        end else begin
          if (wr_ofs < NAME_LEN - 1) begin
            tbl_byte[tbl_cnt][wr_ofs] = w.ch;
            wr_ofs++;
          end
          if (w.fin) begin
            tbl_len[tbl_cnt] = wr_ofs;
            tbl_cnt++;
            wr_ofs = 0;
          end
          push_reply(ST_OK, 0, 0, 0, 1);
        end
      end
      KIND_REMOVE: begin
        if (tbl_cnt == 0) push_reply(ST_EMPTY, 0, 0, 0, 1);
        else if (w.pos == 0 || w.pos > tbl_cnt) push_reply(ST_BADPOS, 0, 0, 0, 1);
        else begin
          for (int i = w.pos; i < tbl_cnt; i++) begin
            tbl_byte[i-1] = tbl_byte[i];
            tbl_len[i-1] = tbl_len[i];
          end
          tbl_cnt--;
          push_reply(ST_OK, 0, 0, 0, 1);
        end
      end
      KIND_SEARCH: begin
        if (pat_len < NAME_LEN - 1) begin
          pat[pat_len] = w.ch;
          pat_len++;
        end
        if (!w.fin) push_reply(ST_OK, 0, 0, 0, 1);
        else if (tbl_cnt == 0) begin
          pat_len = 0;
          push_reply(ST_EMPTY, 0, 0, 0, 1);
        end else begin
          hits = 0;
          for (int i = 0; i < tbl_cnt; i++)
            if (contains(i)) begin
              push_reply(ST_OK, 1, i, 0, 0);
              hits++;
            end
          pat_len = 0;
          if (hits == 0) push_reply(ST_OK, 0, 0, 0, 1);
          else replies[$].fin = 1;
        end
      end
      KIND_SORT: begin
        if (tbl_cnt == 0) push_reply(ST_EMPTY, 0, 0, 0, 1);
        else begin
          for (int i = 0; i + 1 < tbl_cnt; i++)
            for (int j = i + 1; j < tbl_cnt; j++)
              if (name_order(i, j) > 0) begin
                tb = tbl_byte[i]; tbl_byte[i] = tbl_byte[j]; tbl_byte[j] = tb;
                tl = tbl_len[i]; tbl_len[i] = tbl_len[j]; tbl_len[j] = tl;
              end
          push_reply(ST_OK, 0, 0, 0, 1);
        end
      end
      default: begin
        if (tbl_cnt == 0) push_reply(ST_EMPTY, 0, 0, 0, 1);
        else if (w.pos >= tbl_cnt) push_reply(ST_BADPOS, 0, 0, 0, 1);
        else push_reply(ST_OK, 0, 0,
                        w.off < tbl_len[w.pos] ? tbl_byte[w.pos][w.off] : 8'd0, 1);
      end
    endcase
  endfunction

  // sender: bursts and gaps, words change on the falling edge
  int  burst_left = 0, gap_left = 0;
  bit  took;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && !took)) begin
      if (took && pending.size() > 0) void'(pending.pop_front());
      if (pending.size() == 0) in_valid <= 0;
      else if (pending[0].hold && (replies.size() > 0 || gap_left < 50)) begin
        in_valid <= 0;
        gap_left <= replies.size() > 0 ? 0 : gap_left + 1;
      end else if (!pending[0].hold && gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1;
        kind <= pending[0].kind; char_byte <= pending[0].ch; last <= pending[0].fin;
        position <= pending[0].pos; offset <= pending[0].off;
        if (pending[0].hold) gap_left <= 0;
        else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_ready <= 0;
    else case ((stall_phase / 300) % 3)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_phase % 7) < 2;
    endcase
  end

  // monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (replies.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          reply_t e;
          e = replies.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (matched !== e.matched) begin
            $error("matched exp %0d got %0d", e.matched, matched); errors++;
          end
          if (match_index !== e.idx) begin
            $error("match_index exp %0d got %0d", e.idx, match_index); errors++;
          end
          if (byte_out !== e.byte_v) begin
            $error("byte_out exp %0h got %0h", e.byte_v, byte_out); errors++;
          end
          if (count !== e.cnt) begin
            $error("count exp %0d got %0d", e.cnt, count); errors++;
          end
          if (last_result !== e.fin) begin
            $error("last_result exp %0d got %0d", e.fin, last_result); errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        word_t w;
        w.kind = kind; w.ch = char_byte; w.fin = last; w.pos = position; w.off = offset;
        w.hold = 0;
        predict_table(w);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic void put(logic [2:0] k, logic [7:0] c, logic f, logic [5:0] p,
                              logic [4:0] o, bit h = 0);
    word_t w;
    w.kind = k; w.ch = c; w.fin = f; w.pos = p; w.off = o; w.hold = h;
    pending.push_back(w);
  endfunction

  function automatic logic [7:0] pick_char();
    return $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(8'h41, 8'h43));
  endfunction

  function automatic void put_string(logic [2:0] k, int n);
    for (int i = 0; i < n; i++) put(k, pick_char(), i == n - 1, 6'($urandom), 5'($urandom));
  endfunction

  initial begin
    int r, fill;
    tbl_cnt = 0; pat_len = 0; wr_ofs = 0;
    rst = 1; in_valid = 0; out_ready = 0;
    kind = 0; char_byte = 0; last = 0; position = 0; offset = 0;
    // empty table cases and unknown kinds, then directed corner cases for every kind
    put(KIND_REMOVE, 0, 0, 1, 0);
    put(KIND_READ, 0, 0, 0, 0);
    put(KIND_SORT, 0, 0, 0, 0);
    put(KIND_SEARCH, 8'h41, 1, 0, 0);
    put(3'd5, 8'hff, 1, 6'h3f, 5'h1f);
    put(3'd6, 0, 0, 0, 0);
    put(3'd7, 0, 0, 0, 0);
    put(KIND_ADD, 8'h00, 1, 0, 0);
    put(KIND_ADD, 8'hff, 0, 0, 0);
    put(KIND_ADD, 8'h80, 1, 0, 0);
    for (int i = 0; i < 40; i++) put(KIND_ADD, 8'(8'h30 + i), i == 39, 0, 0);
    put(KIND_ADD, 8'h41, 0, 0, 0);
    put(KIND_READ, 0, 0, 2, 5'd30);
    put(KIND_SEARCH, 8'h42, 0, 0, 0);
    put(KIND_SORT, 0, 0, 0, 0);
    put(KIND_SEARCH, 8'hff, 1, 0, 0);
    put(KIND_SEARCH, 8'h55, 1, 0, 0);
    put(KIND_REMOVE, 0, 0, 0, 0);
    put(KIND_REMOVE, 0, 0, 6'd33, 0);
    put(KIND_READ, 0, 0, 6'd3, 0);
    put(KIND_READ, 0, 0, 0, 5'd31);
    put(KIND_REMOVE, 0, 0, 6'd3, 0);
    for (int i = 0; i < 31; i++) put(KIND_ADD, 8'($urandom), 1, 0, 0);
    put(KIND_ADD, 8'h41, 0, 0, 0);
    put(KIND_ADD, 8'h42, 1, 0, 0);
    put(KIND_SORT, 0, 0, 0, 0);
    put(KIND_REMOVE, 0, 0, 6'd32, 0);
    put(KIND_REMOVE, 0, 0, 6'd1, 0, 1);
    for (int i = 0; i < 26; i++) put(KIND_REMOVE, 0, 0, 6'd1, 0);
    // random mix, mostly well-formed names and patterns
    for (int n = 0; n < 290; ) begin
      if (n == 200) put(KIND_READ, 0, 0, 0, 0, 1);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        fill = $urandom_range(0, 15) == 0 ? $urandom_range(28, 36) : $urandom_range(1, 6);
        put_string(KIND_ADD, fill); n += fill;
      end else if (r < 55) begin
        fill = $urandom_range(1, 3);
        put_string(KIND_SEARCH, fill); n += fill;
      end else if (r < 70) begin
        put(KIND_REMOVE, 0, 0, $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(1, 8)),
            5'($urandom));
        n++;
      end else if (r < 88) begin
        put(KIND_READ, 8'($urandom), 1'($urandom),
            $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 10)), 5'($urandom));
        n++;
      end else if (r < 91) begin
        put(KIND_SORT, 0, 0, 0, 0); n++;
      end else if (r < 95) begin
        put($urandom_range(0, 1) ? KIND_ADD : KIND_SEARCH, pick_char(), 0, 0, 0); n++;
      end else begin
        put(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 6'($urandom), 5'($urandom));
        n++;
      end
    end
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (pending.size() == 0 && !in_valid);
    wait (replies.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
